@@ design/jscmd_pkg.sv @@
// Package with the shared types, codes and constants of the JTAG shift command engine.
package jscmd_pkg;

  localparam int unsigned MAX_SHIFT_BITS_DEF = 8192;
  localparam int unsigned RES_SLOTS = 4;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_PORT  = 4'd1,
    PH_FEAT1 = 4'd2,
    PH_FEAT2 = 4'd3,
    PH_UART1 = 4'd4,
    PH_UART2 = 4'd5,
    PH_UART3 = 4'd6,
    PH_LENHI = 4'd7,
    PH_LENLO = 4'd8,
    PH_TDI   = 4'd9,
    PH_TMS   = 4'd10,
    PH_WAIT  = 4'd11
  } phase_e;

  typedef enum logic [1:0] {
    KIND_REPLY = 2'd0,
    KIND_DRIVE = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_LEAVE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_PORT_MODE   = 3'd0,
    ERR_ACTION      = 3'd1,
    ERR_FEATURE     = 3'd2,
    ERR_UNSUPPORTED = 3'd3,
    ERR_LENGTH      = 3'd4
  } err_e;

  typedef enum logic {
    REQ_HOST_BYTE  = 1'b0,
    REQ_TDO_SAMPLE = 1'b1
  } req_e;

  // Command codes seen in idle.
  localparam logic [7:0] CMD_LEAVE       = 8'h00;
  localparam logic [7:0] CMD_PIN_MODE    = 8'h01;
  localparam logic [7:0] CMD_SET_FEATURE = 8'h02;
  localparam logic [7:0] CMD_READ_ADC    = 8'h03;
  localparam logic [7:0] CMD_SCAN        = 8'h05;
  localparam logic [7:0] CMD_REWELCOME   = 8'h06;
  localparam logic [7:0] CMD_BAUD_ECHO   = 8'h07;
  localparam logic [7:0] CMD_TCK_RATE    = 8'h08;

  // Feature codes.
  localparam logic [7:0] FEAT_LED     = 8'h01;
  localparam logic [7:0] FEAT_VREG    = 8'h02;
  localparam logic [7:0] FEAT_TRST    = 8'h04;
  localparam logic [7:0] FEAT_SRST    = 8'h08;
  localparam logic [7:0] FEAT_PULLUPS = 8'h10;

  localparam logic [1:0] PORT_MODE_MAX = 2'd2;

  // Re-welcome text "OCD1".
  localparam logic [7:0] WELCOME_TEXT [RES_SLOTS] = '{8'h4F, 8'h43, 8'h44, 8'h31};

  typedef struct packed {
    req_e       req_type;
    logic [7:0] rx_byte;
    logic       tdo_level;
  } req_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] tx;
    logic       tdi;
    logic       tms;
    err_e       err;
  } res_entry_t;

  typedef struct packed {
    logic [1:0] port_mode;
    logic       pullups;
    logic       trst;
    logic       srst;
  } pins_t;

  typedef struct packed {
    logic [2:0]                      count;
    res_entry_t [RES_SLOTS-1:0]      entry;
    pins_t                           pins;
  } batch_t;

  function automatic res_entry_t mk_res(kind_e kind, logic [7:0] tx, logic tdi, logic tms,
                                        err_e err);
    res_entry_t r;
    r.kind = kind;
    r.tx   = tx;
    r.tdi  = tdi;
    r.tms  = tms;
    r.err  = err;
    return r;
  endfunction

endpackage

@@ design/jscmd_req_if.sv @@
// Interface of the input channel: host bytes and TDO samples.
interface jscmd_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;
  logic       tdo_level;

  modport source (output valid, req_type, rx_byte, tdo_level, input ready);
  modport sink   (input valid, req_type, rx_byte, tdo_level, output ready);
endinterface

@@ design/jscmd_res_if.sv @@
// Interface of the result channel: reply bytes, TCK requests, errors and leave notices.
interface jscmd_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] tx_byte;
  logic       tdi_bit;
  logic       tms_bit;
  logic [2:0] error_code;
  logic [1:0] port_mode;
  logic       pullups_on;
  logic       trst_level;
  logic       srst_level;
  logic       last;

  modport source (output valid, result_kind, tx_byte, tdi_bit, tms_bit, error_code, port_mode,
                  pullups_on, trst_level, srst_level, last, input ready);
  modport sink   (input valid, result_kind, tx_byte, tdi_bit, tms_bit, error_code, port_mode,
                  pullups_on, trst_level, srst_level, last, output ready);
endinterface

@@ design/jtag_shift_command_engine_unit.sv @@
// Top level of the JTAG shift command engine: input register, parser and result register.
//
//   Channel | Direction | Item carries
//   --------+-----------+-----------------------------------------------------------
//   req_i   | in        | req_type, rx_byte (host byte), tdo_level (TDO sample)
//   res_o   | out       | result_kind, tx_byte, tdi_bit, tms_bit, error_code,
//           |           | port_mode, pullups_on, trst_level, srst_level, last
//
// An item is held in the input register and is parsed in the cycle it moves into the result
// register, so its first result is offered on res_o once the result register holds it.
// One item is taken per cycle as long as each item yields at most one result and res_o
// does not stall; an item that yields several results (at most four, for the re-welcome
// text) holds the result register until its last result is taken, and the next item
// waits in the input register meanwhile.
// Reset is asynchronous and active low; it puts the parser in idle, the pins in high
// impedance with pull-ups off and TRST and SRST high, and empties both registers.
// A stall on res_o backs up into the input register and then drops req_i.ready.
module jtag_shift_command_engine_unit import jscmd_pkg::*; #(
  parameter int unsigned MAX_SHIFT_BITS = MAX_SHIFT_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  jscmd_req_if.sink   req_i,
  jscmd_res_if.source res_o
);

  logic       in_valid_q;
  req_t       in_q;
  logic       take;
  logic       free;
  logic       accept;
  batch_t     batch;
  res_entry_t out_entry;
  pins_t      out_pins;

  // The input register takes a new item whenever it is empty or its item moves on.
  assign take        = in_valid_q && free;
  assign req_i.ready = !in_valid_q || take;
  assign accept      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept || (in_valid_q && !take);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= '{req_type: req_e'(req_i.req_type), rx_byte: req_i.rx_byte,
                tdo_level: req_i.tdo_level};
    end
  end

  // The parser updates its state and forms the whole batch of results in one step.
  jscmd_parser #(
    .MAX_SHIFT_BITS(MAX_SHIFT_BITS)
  ) u_parser (
    .clk_i,
    .rst_ni,
    .take_i (take),
    .item_i (in_q),
    .batch_o(batch)
  );

  // The result register serializes the batch onto res_o.
  jscmd_outbuf u_outbuf (
    .clk_i,
    .rst_ni,
    .load_i     (take),
    .batch_i    (batch),
    .out_ready_i(res_o.ready),
    .out_valid_o(res_o.valid),
    .out_entry_o(out_entry),
    .out_pins_o (out_pins),
    .out_last_o (res_o.last),
    .free_o     (free)
  );

  assign res_o.result_kind = out_entry.kind;
  assign res_o.tx_byte     = out_entry.tx;
  assign res_o.tdi_bit     = out_entry.tdi;
  assign res_o.tms_bit     = out_entry.tms;
  assign res_o.error_code  = out_entry.err;
  assign res_o.port_mode   = out_pins.port_mode;
  assign res_o.pullups_on  = out_pins.pullups;
  assign res_o.trst_level  = out_pins.trst;
  assign res_o.srst_level  = out_pins.srst;

endmodule

@@ design/jscmd_parser.sv @@
// Command parser and TAP shift state: turns one item into a batch of up to four results.
module jscmd_parser import jscmd_pkg::*; #(
  parameter int unsigned MAX_SHIFT_BITS = MAX_SHIFT_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   take_i,
  input  req_t   item_i,
  output batch_t batch_o
);

  localparam logic [15:0] MaxLen = 16'(MAX_SHIFT_BITS);

  phase_e      phase_q, phase_d;
  logic [7:0]  arg0_q, arg0_d;
  logic [15:0] rem_q, rem_d;
  logic [7:0]  tdi_q, tdi_d;
  logic [7:0]  tms_q, tms_d;
  logic [7:0]  tdo_q, tdo_d;
  logic [3:0]  bib_q, bib_d;
  pins_t       pins_q, pins_d;

  logic [7:0]  b;
  logic [15:0] len;
  logic [15:0] rem_dec;
  logic [3:0]  bib_dec;
  logic [3:0]  bib_new;
  logic [7:0]  tdo_new;

  assign b       = item_i.rx_byte;
  assign len     = {arg0_q, b};
  assign rem_dec = (rem_q != 16'd0) ? rem_q - 16'd1 : rem_q;
  assign bib_dec = (bib_q != 4'd0) ? bib_q - 4'd1 : bib_q;
  assign bib_new = (rem_q >= 16'd8) ? 4'd8 : rem_q[3:0];
  assign tdo_new = {item_i.tdo_level, tdo_q[7:1]};

  always_comb begin
    phase_d = phase_q;
    arg0_d  = arg0_q;
    rem_d   = rem_q;
    tdi_d   = tdi_q;
    tms_d   = tms_q;
    tdo_d   = tdo_q;
    bib_d   = bib_q;
    pins_d  = pins_q;
    batch_o = '0;

    if (item_i.req_type == REQ_HOST_BYTE) begin
      unique case (phase_q)
        PH_IDLE: begin
          unique case (b)
            CMD_LEAVE: begin
              pins_d = '{port_mode: 2'd0, pullups: 1'b0, trst: 1'b1, srst: 1'b1};
              batch_o.count    = 3'd1;
              batch_o.entry[0] = mk_res(KIND_LEAVE, 8'h00, 1'b0, 1'b0, ERR_PORT_MODE);
            end
            CMD_REWELCOME: begin
              batch_o.count = 3'd4;
              for (int i = 0; i < RES_SLOTS; i++) begin
                batch_o.entry[i] = mk_res(KIND_REPLY, WELCOME_TEXT[i], 1'b0, 1'b0,
                                          ERR_PORT_MODE);
              end
            end
            CMD_READ_ADC, CMD_TCK_RATE: begin
              batch_o.count    = 3'd1;
              batch_o.entry[0] = mk_res(KIND_ERROR, 8'h00, 1'b0, 1'b0, ERR_UNSUPPORTED);
            end
            CMD_PIN_MODE:    phase_d = PH_PORT;
            CMD_SET_FEATURE: phase_d = PH_FEAT1;
            CMD_BAUD_ECHO:   phase_d = PH_UART1;
            CMD_SCAN:        phase_d = PH_LENHI;
            default: begin
              // Unknown code: answer with a zero byte and stay idle.
              batch_o.count    = 3'd1;
              batch_o.entry[0] = mk_res(KIND_REPLY, 8'h00, 1'b0, 1'b0, ERR_PORT_MODE);
            end
          endcase
        end
        PH_PORT: begin
          phase_d = PH_IDLE;
          if (b > {6'd0, PORT_MODE_MAX}) begin
            batch_o.count    = 3'd1;
            batch_o.entry[0] = mk_res(KIND_ERROR, 8'h00, 1'b0, 1'b0, ERR_PORT_MODE);
          end else begin
            pins_d.port_mode = b[1:0];
          end
        end
        PH_FEAT1: begin
          arg0_d  = b;
          phase_d = PH_FEAT2;
        end
        PH_FEAT2: begin
          phase_d = PH_IDLE;
          if (b > 8'd1) begin
            batch_o.count    = 3'd1;
            batch_o.entry[0] = mk_res(KIND_ERROR, 8'h00, 1'b0, 1'b0, ERR_ACTION);
          end else if (arg0_q == FEAT_PULLUPS) begin
            pins_d.pullups = b[0];
          end else if (arg0_q == FEAT_TRST) begin
            pins_d.trst = b[0];
          end else if (arg0_q == FEAT_SRST) begin
            pins_d.srst = b[0];
          end else if (arg0_q != FEAT_LED && arg0_q != FEAT_VREG) begin
            batch_o.count    = 3'd1;
            batch_o.entry[0] = mk_res(KIND_ERROR, 8'h00, 1'b0, 1'b0, ERR_FEATURE);
          end
        end
        PH_UART1: begin
          arg0_d  = b;
          phase_d = PH_UART2;
        end
        PH_UART2: phase_d = PH_UART3;
        PH_UART3: begin
          phase_d          = PH_IDLE;
          batch_o.count    = 3'd2;
          batch_o.entry[0] = mk_res(KIND_REPLY, CMD_BAUD_ECHO, 1'b0, 1'b0, ERR_PORT_MODE);
          batch_o.entry[1] = mk_res(KIND_REPLY, arg0_q, 1'b0, 1'b0, ERR_PORT_MODE);
        end
        PH_LENHI: begin
          arg0_d  = b;
          phase_d = PH_LENLO;
        end
        PH_LENLO: begin
          if (len > MaxLen) begin
            rem_d            = 16'd0;
            phase_d          = PH_IDLE;
            batch_o.count    = 3'd1;
            batch_o.entry[0] = mk_res(KIND_ERROR, 8'h00, 1'b0, 1'b0, ERR_LENGTH);
          end else begin
            rem_d            = len;
            phase_d          = (len == 16'd0) ? PH_IDLE : PH_TDI;
            batch_o.count    = 3'd3;
            batch_o.entry[0] = mk_res(KIND_REPLY, CMD_SCAN, 1'b0, 1'b0, ERR_PORT_MODE);
            batch_o.entry[1] = mk_res(KIND_REPLY, arg0_q, 1'b0, 1'b0, ERR_PORT_MODE);
            batch_o.entry[2] = mk_res(KIND_REPLY, b, 1'b0, 1'b0, ERR_PORT_MODE);
          end
        end
        PH_TDI: begin
          tdi_d   = b;
          phase_d = PH_TMS;
        end
        PH_TMS: begin
          tms_d = b;
          bib_d = bib_new;
          tdo_d = 8'h00;
          if (bib_new == 4'd0) begin
            phase_d = PH_IDLE;
          end else begin
            batch_o.count    = 3'd1;
            batch_o.entry[0] = mk_res(KIND_DRIVE, 8'h00, tdi_q[0], b[0], ERR_PORT_MODE);
            tdi_d            = {1'b0, tdi_q[7:1]};
            tms_d            = {1'b0, b[7:1]};
            phase_d          = PH_WAIT;
          end
        end
        default: ;  // Host bytes are dropped while a TDO sample is pending.
      endcase
    end else if (phase_q == PH_WAIT) begin
      tdo_d = tdo_new;
      rem_d = rem_dec;
      bib_d = bib_dec;
      batch_o.count = 3'd1;
      if (bib_dec != 4'd0) begin
        batch_o.entry[0] = mk_res(KIND_DRIVE, 8'h00, tdi_q[0], tms_q[0], ERR_PORT_MODE);
        tdi_d            = {1'b0, tdi_q[7:1]};
        tms_d            = {1'b0, tms_q[7:1]};
      end else begin
        batch_o.entry[0] = mk_res(KIND_REPLY, tdo_new, 1'b0, 1'b0, ERR_PORT_MODE);
        phase_d          = (rem_dec == 16'd0) ? PH_IDLE : PH_TDI;
      end
    end

    batch_o.pins = pins_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      arg0_q  <= 8'h00;
      rem_q   <= 16'd0;
      tdi_q   <= 8'h00;
      tms_q   <= 8'h00;
      tdo_q   <= 8'h00;
      bib_q   <= 4'd0;
      pins_q  <= '{port_mode: 2'd0, pullups: 1'b0, trst: 1'b1, srst: 1'b1};
    end else if (take_i) begin
      phase_q <= phase_d;
      arg0_q  <= arg0_d;
      rem_q   <= rem_d;
      tdi_q   <= tdi_d;
      tms_q   <= tms_d;
      tdo_q   <= tdo_d;
      bib_q   <= bib_d;
      pins_q  <= pins_d;
    end
  end

endmodule

@@ design/jscmd_outbuf.sv @@
// Result register: holds one batch and hands its results out one per handshake.
module jscmd_outbuf import jscmd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  batch_t     batch_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output res_entry_t out_entry_o,
  output pins_t      out_pins_o,
  output logic       out_last_o,
  output logic       free_o
);

  logic [2:0]                 rem_q;
  logic [1:0]                 idx_q;
  res_entry_t [RES_SLOTS-1:0] entry_q;
  pins_t                      pins_q;
  logic                       pop;

  assign out_valid_o = (rem_q != 3'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_entry_o = entry_q[idx_q];
  assign out_pins_o  = pins_q;
  assign out_last_o  = (rem_q == 3'd1);
  // Room for a new batch once the last result of the current one leaves.
  assign free_o      = (rem_q == 3'd0) || (out_last_o && out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
      idx_q <= 2'd0;
    end else if (load_i) begin
      rem_q <= batch_i.count;
      idx_q <= 2'd0;
    end else if (pop) begin
      rem_q <= rem_q - 3'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      entry_q <= batch_i.entry;
      pins_q  <= batch_i.pins;
    end
  end

endmodule

@@ design/jscmd_checker.sv @@
// Port-level checker of the JTAG shift command engine, bound to the top level.
module jscmd_props import jscmd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [1:0] result_kind_i,
  input logic [7:0] tx_byte_i,
  input logic       tdi_bit_i,
  input logic       tms_bit_i,
  input logic [2:0] error_code_i,
  input logic [1:0] port_mode_i,
  input logic       pullups_on_i,
  input logic       trst_level_i,
  input logic       srst_level_i
);

  // A result that is shown stays shown until it is taken.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result withdrawn before it was taken");

  // A leave notice reports the pins already back in their safe state.
  a_leave_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && result_kind_i == KIND_LEAVE |->
      port_mode_i == 2'd0 && !pullups_on_i && trst_level_i && srst_level_i)
    else $error("leave notice with pins not in the safe state");

  // Only TCK requests carry pin levels, and only errors carry a code.
  a_field_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (result_kind_i == KIND_DRIVE || (!tdi_bit_i && !tms_bit_i)) &&
                    (result_kind_i == KIND_ERROR || error_code_i == ERR_PORT_MODE))
    else $error("result carries fields that do not belong to its kind");

  // Replies aside, no result carries a byte, and the pin mode is never the unused code.
  a_tx_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (result_kind_i == KIND_REPLY || tx_byte_i == 8'h00) &&
                    port_mode_i != 2'd3)
    else $error("non-reply byte or invalid pin mode on the result channel");

endmodule

bind jtag_shift_command_engine_unit jscmd_props u_jscmd_props (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .result_kind_i(res_o.result_kind),
  .tx_byte_i    (res_o.tx_byte),
  .tdi_bit_i    (res_o.tdi_bit),
  .tms_bit_i    (res_o.tms_bit),
  .error_code_i (res_o.error_code),
  .port_mode_i  (res_o.port_mode),
  .pullups_on_i (res_o.pullups_on),
  .trst_level_i (res_o.trst_level),
  .srst_level_i (res_o.srst_level)
);
